// ----- rtl/core/md5ds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package md5ds_pkg;

  // Field and storage widths.
  localparam int WORD_W      = 32;
  localparam int COUNT_W     = 3;
  localparam int INDEX_W     = 2;
  localparam int LEN_W       = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int FILL_W      = $clog2(BLOCK_WORDS);
  localparam int ROUNDS      = 64;
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int CHAIN_WORDS = 4;

  // Slot that receives the low length word; the high word follows in the last slot.
  localparam logic [FILL_W-1:0] LEN_LO_SLOT = FILL_W'(BLOCK_WORDS - 2);
  localparam logic [FILL_W-1:0] LAST_SLOT   = FILL_W'(BLOCK_WORDS - 1);

  // Padding marker byte and full word byte count.
  localparam logic [WORD_W-1:0]  PAD_MARK   = 32'h0000_0080;
  localparam logic [COUNT_W-1:0] FULL_BYTES = 3'd4;

  // Chaining value after reset, element 0 is word A.
  localparam logic [CHAIN_WORDS-1:0][WORD_W-1:0] INIT_CHAIN = {
    32'h1032_5476, 32'h98BA_DCFE, 32'hEFCD_AB89, 32'h6745_2301
  };

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic load;    // copy chaining value into the working registers
    logic step;    // run one round
    logic finish;  // fold working registers into the chaining value
    logic reinit;  // return chaining value to its initial words
  } round_ctl_t;

  // Per-round additive constant.
  function automatic logic [WORD_W-1:0] sine_k(input logic [ROUND_W-1:0] r);
    logic [WORD_W-1:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Rotate amount, chosen by round group and the two low round bits.
  function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Message word used by a round; all products wrap modulo the block size.
  function automatic logic [FILL_W-1:0] msg_index(input logic [ROUND_W-1:0] r);
    logic [FILL_W-1:0] lo;
    logic [FILL_W-1:0] idx;
    lo = r[FILL_W-1:0];
    unique case (r[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = (lo << 2) + lo + 4'd1;
      2'd2:    idx = (lo << 1) + lo + 4'd5;
      2'd3:    idx = (lo << 3) - lo;
      default: idx = lo;
    endcase
    return idx;
  endfunction

  // 32-bit rotate left.
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [4:0] s);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << s;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/md5ds_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Message channel: one item is one little-endian message word.
interface md5ds_in_if;
  logic                               valid;
  logic                               ready;
  logic [md5ds_pkg::WORD_W-1:0]       data_word;
  logic [md5ds_pkg::COUNT_W-1:0]      valid_bytes;
  logic                               final_word;

  modport source (output valid, output data_word, output valid_bytes,
                  output final_word, input ready);
  modport sink   (input valid, input data_word, input valid_bytes,
                  input final_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/md5ds_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Digest channel: one item is one chaining word of the finished digest.
interface md5ds_out_if;
  logic                               valid;
  logic                               ready;
  logic [md5ds_pkg::WORD_W-1:0]       digest_word;
  logic [md5ds_pkg::INDEX_W-1:0]      word_index;
  logic                               last_out;

  modport source (output valid, output digest_word, output word_index,
                  output last_out, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/md5ds_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one read port, registered read data.
module md5ds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/md5ds_round.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Round datapath: working registers A..D, one round per step, and the
// chaining value that the working registers fold into after each block.
module md5ds_round (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire md5ds_pkg::round_ctl_t               ctl,
  input  wire logic [md5ds_pkg::ROUND_W-1:0]       round,
  input  wire logic [md5ds_pkg::WORD_W-1:0]        msg_word,
  input  wire logic [md5ds_pkg::INDEX_W-1:0]       word_sel,
  output      logic [md5ds_pkg::WORD_W-1:0]        chain_word
);

  logic [md5ds_pkg::CHAIN_WORDS-1:0][md5ds_pkg::WORD_W-1:0] chain;
  logic [md5ds_pkg::WORD_W-1:0] a;
  logic [md5ds_pkg::WORD_W-1:0] b;
  logic [md5ds_pkg::WORD_W-1:0] c;
  logic [md5ds_pkg::WORD_W-1:0] d;
  logic [md5ds_pkg::WORD_W-1:0] fn;
  logic [md5ds_pkg::WORD_W-1:0] sum;
  logic [md5ds_pkg::WORD_W-1:0] b_next;

  // Boolean function of the current round group.
  always_comb begin
    case (round[5:4])
      2'd0:    fn = (b & c) | (~b & d);
      2'd1:    fn = (b & d) | (c & ~d);
      2'd2:    fn = b ^ c ^ d;
      default: fn = c ^ (b | ~d);
    endcase
  end

  // One round: four-term sum, rotate, add B.
  assign sum    = fn + a + msg_word + md5ds_pkg::sine_k(round);
  assign b_next = b + md5ds_pkg::rotl(sum, md5ds_pkg::rot_amount(round));

  // Working registers need no reset; they are loaded before every block.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (ctl.step) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_next;
    end
  end

  // Chaining value.
  always_ff @(posedge clk) begin
    if (rst || ctl.reinit) begin
      chain <= md5ds_pkg::INIT_CHAIN;
    end else if (ctl.finish) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

  assign chain_word = chain[word_sel];

endmodule

`default_nettype wire

// ----- rtl/core/md5_digest_stream_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming MD5 hash. Message words enter on msg, first byte in bits 7:0; the
// word flagged final_word closes the message, and after padding and the last
// compression the four digest words A, B, C, D leave on digest, last_out set
// on D. Words go into a 16-entry message RAM at one word per cycle; when the
// block is full the sequencer runs the 64 rounds on a single round unit, one
// round per cycle; as the RAM read is registered, the next round's message
// word is fetched while the current round runs. A full block takes 16 writes,
// a RAM prime step, 64 rounds and a fold into the chaining value, and msg is
// not ready while the rounds run. A final word adds one padding write per
// remaining slot, one or two compressions and four digest words; the next
// message is taken once D has been delivered. No clearing pass follows reset.
module md5_digest_stream_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  md5ds_in_if.sink        msg,
  md5ds_out_if.source     digest
);

  // Sequencer states.
  localparam logic [2:0] S_FILL   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_PRIME  = 3'd2;
  localparam logic [2:0] S_ROUND  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // Padding phases.
  localparam logic [1:0] PH_MARK = 2'd0;  // 0x80 word after a full final word
  localparam logic [1:0] PH_ZERO = 2'd1;  // zero words, then the low length word
  localparam logic [1:0] PH_HI   = 2'd2;  // high length word
  localparam logic [1:0] PH_DONE = 2'd3;  // padding written, digest follows

  localparam logic [md5ds_pkg::INDEX_W-1:0] LAST_INDEX = '1;

  logic [2:0]                          state;
  logic [2:0]                          state_next;
  logic [md5ds_pkg::FILL_W-1:0]        fill;
  logic [md5ds_pkg::FILL_W-1:0]        fill_next;
  logic [1:0]                          phase;
  logic [1:0]                          phase_next;
  logic                                padding;
  logic                                padding_next;
  logic [md5ds_pkg::ROUND_W-1:0]       round_count;
  logic [md5ds_pkg::ROUND_W-1:0]       round_count_next;
  logic [md5ds_pkg::LEN_W-1:0]         bit_length;
  logic [md5ds_pkg::LEN_W-1:0]         bit_length_next;
  logic [md5ds_pkg::INDEX_W-1:0]       out_index;
  logic [md5ds_pkg::INDEX_W-1:0]       out_index_next;

  logic                                put;
  logic                                wr_en;
  logic [md5ds_pkg::WORD_W-1:0]        wr_data;
  logic [md5ds_pkg::FILL_W-1:0]        rd_addr;
  logic [md5ds_pkg::WORD_W-1:0]        rd_data;
  logic [md5ds_pkg::COUNT_W-1:0]       nbytes;
  logic [md5ds_pkg::WORD_W-1:0]        first_word;
  md5ds_pkg::round_ctl_t               ctl;

  // Byte count of the final word, clamped to four.
  assign nbytes = (msg.valid_bytes > md5ds_pkg::FULL_BYTES) ? md5ds_pkg::FULL_BYTES
                                                            : msg.valid_bytes;

  // Final word with unused bytes cleared and the padding marker appended.
  always_comb begin
    case (nbytes)
      3'd0:    first_word = md5ds_pkg::PAD_MARK;
      3'd1:    first_word = {16'h0000, 8'h80, msg.data_word[7:0]};
      3'd2:    first_word = {8'h00, 8'h80, msg.data_word[15:0]};
      3'd3:    first_word = {8'h80, msg.data_word[23:0]};
      default: first_word = msg.data_word;
    endcase
  end

  // Sequencer: fill the block, pad, compress, deliver the digest.
  always_comb begin
    state_next       = state;
    fill_next        = fill;
    phase_next       = phase;
    padding_next     = padding;
    round_count_next = round_count;
    bit_length_next  = bit_length;
    out_index_next   = out_index;
    put              = 1'b0;
    wr_data          = '0;
    rd_addr          = md5ds_pkg::msg_index('0);
    ctl              = '0;

    unique case (state)
      S_FILL: begin
        if (msg.valid) begin
          put = 1'b1;
          if (msg.final_word) begin
            wr_data         = first_word;
            bit_length_next = bit_length + {58'd0, nbytes, 3'd0};
            padding_next    = 1'b1;
            phase_next      = (nbytes == md5ds_pkg::FULL_BYTES) ? PH_MARK : PH_ZERO;
            state_next      = S_PAD;
          end else begin
            wr_data         = msg.data_word;
            bit_length_next = bit_length + 64'd32;
          end
        end
      end
      S_PAD: begin
        put = 1'b1;
        case (phase)
          PH_MARK: begin
            wr_data    = md5ds_pkg::PAD_MARK;
            phase_next = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill == md5ds_pkg::LEN_LO_SLOT) begin
              wr_data    = bit_length[31:0];
              phase_next = PH_HI;
            end else begin
              wr_data = '0;
            end
          end
          PH_HI: begin
            wr_data    = bit_length[63:32];
            phase_next = PH_DONE;
          end
          default: begin
            put = 1'b0;
          end
        endcase
      end
      S_PRIME: begin
        ctl.load         = 1'b1;
        rd_addr          = md5ds_pkg::msg_index('0);
        round_count_next = '0;
        state_next       = S_ROUND;
      end
      S_ROUND: begin
        ctl.step         = 1'b1;
        rd_addr          = md5ds_pkg::msg_index(round_count + 6'd1);
        round_count_next = round_count + 6'd1;
        if (round_count == 6'(md5ds_pkg::ROUNDS - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        if (!padding) begin
          state_next = S_FILL;
        end else if (phase == PH_DONE) begin
          out_index_next = '0;
          state_next     = S_OUT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_OUT: begin
        if (digest.ready) begin
          out_index_next = out_index + 2'd1;
          if (out_index == LAST_INDEX) begin
            ctl.reinit      = 1'b1;
            bit_length_next = '0;
            fill_next       = '0;
            padding_next    = 1'b0;
            state_next      = S_FILL;
          end
        end
      end
      default: begin
        state_next = S_FILL;
      end
    endcase

    // Each written word advances the fill slot; a full block starts a compression.
    if (put) begin
      fill_next = fill + 4'd1;
      if (fill == md5ds_pkg::LAST_SLOT) begin
        state_next = S_PRIME;
      end
    end
  end

  assign wr_en = put;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      fill        <= '0;
      phase       <= PH_ZERO;
      padding     <= 1'b0;
      round_count <= '0;
      bit_length  <= '0;
      out_index   <= '0;
    end else begin
      state       <= state_next;
      fill        <= fill_next;
      phase       <= phase_next;
      padding     <= padding_next;
      round_count <= round_count_next;
      bit_length  <= bit_length_next;
      out_index   <= out_index_next;
    end
  end

  // Message block store.
  md5ds_ram #(
    .WIDTH (md5ds_pkg::WORD_W),
    .DEPTH (md5ds_pkg::BLOCK_WORDS)
  ) u_block_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Round unit and chaining value.
  md5ds_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .round      (round_count),
    .msg_word   (rd_data),
    .word_sel   (out_index),
    .chain_word (digest.digest_word)
  );

  // Channel handshakes.
  assign msg.ready         = (state == S_FILL);
  assign digest.valid      = (state == S_OUT);
  assign digest.word_index = out_index;
  assign digest.last_out   = (out_index == LAST_INDEX);

  // The block never takes a message item while a digest item is offered.
  assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("message accepted while digest is pending");

  // Every compression ends with the round counter back at zero.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> (round_count == '0))
    else $error("round counter out of step at block end");

  // A compression only starts on a completely filled block.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PRIME) |-> ((fill == '0) && $past(wr_en)))
    else $error("compression started on a partial block");

  // After the last digest item the block is ready for a new message.
  assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_out) |=>
      (msg.ready && (bit_length == '0) && (fill == '0)))
    else $error("block not re-armed after digest");

endmodule

`default_nettype wire
